// File: src/playfair_encrypt_defines.svh
// Assertion macros used by the top level of the playfair encryptor.
`ifndef PLAYFAIR_ENCRYPT_DEFINES_SVH
`define PLAYFAIR_ENCRYPT_DEFINES_SVH
`ifndef SYNTH
`define PFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfe check failed");
`define PFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfe check failed");
`else
`define PFE_ASSERT_SAME(label, ante, cons)
`define PFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/pfe_pkg.sv
// Types, constants and helper functions of the playfair encryptor.
package pfe_pkg;

  localparam int CH_W            = 7;
  localparam int IDX_W           = 5;
  localparam int RC_W            = 3;
  localparam int SQ_SIDE         = 5;
  localparam int SQ_CELLS        = 25;
  localparam int ALPHA_LEN       = 26;
  localparam int PFE_QUEUE_DEPTH = 2;

  localparam logic [CH_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CH_W-1:0] CH_PAD   = 7'h78;
  localparam logic [CH_W-1:0] CH_LOW_A = 7'h61;
  localparam logic [CH_W-1:0] CH_LOW_J = 7'h6A;

  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_MSG = 1'b1;

  localparam logic [RC_W-1:0] CELL_ROW [SQ_CELLS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4};

  localparam logic [RC_W-1:0] CELL_COL [SQ_CELLS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_PAIR = 1'b1
  } op_kind_t;

  // Key op: a = key char. Pair op: a, b = plaintext pair, last = final pair.
  typedef struct packed {
    op_kind_t          kind;
    logic [CH_W-1:0]   a;
    logic [CH_W-1:0]   b;
    logic              first;
    logic              last;
  } pfe_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pfe_qstat_t;

  typedef struct packed {
    logic [IDX_W-1:0] fill;
  } pfe_bstat_t;

  function automatic logic [IDX_W-1:0] cell_idx(input logic [RC_W-1:0] row,
                                                input logic [RC_W-1:0] col);
    cell_idx = IDX_W'({row, 2'b00}) + IDX_W'(row) + IDX_W'(col);
  endfunction

  function automatic logic [RC_W-1:0] inc5(input logic [RC_W-1:0] v);
    inc5 = (v == RC_W'(SQ_SIDE - 1)) ? '0 : v + 3'd1;
  endfunction

endpackage

// File: src/pfe_in_if.sv
// Input channel of the playfair encryptor: key and message characters.
interface pfe_in_if;
  import pfe_pkg::*;

  logic            valid;
  logic            ready;
  logic            cmd;
  logic [CH_W-1:0] ch;
  logic            first;
  logic            last;

  modport source (output valid, output cmd, output ch, output first, output last,
                  input ready);
  modport sink (input valid, input cmd, input ch, input first, input last,
                output ready);
endinterface

// File: src/pfe_out_if.sv
// Output channel of the playfair encryptor: ciphertext pairs.
interface pfe_out_if;
  import pfe_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] cipher_first;
  logic [CH_W-1:0] cipher_second;
  logic            final_pair;

  modport source (output valid, output cipher_first, output cipher_second,
                  output final_pair, input ready);
  modport sink (input valid, input cipher_first, input cipher_second,
                input final_pair, output ready);
endinterface

// File: src/pfe_ram.sv
// Generic single write port RAM with registered read.
module pfe_ram #(
  parameter int WIDTH = pfe_pkg::CH_W,
  parameter int DEPTH = pfe_pkg::SQ_CELLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: src/pfe_front.sv
// Front end: takes input transfers, drops spaces, applies the double-letter rule, forms pairs.
module pfe_front (
  input  logic                clk,
  input  logic                rst_n,
  pfe_in_if.sink              in_chan,
  input  pfe_pkg::pfe_qstat_t q_stat,
  output logic                push,
  output pfe_pkg::pfe_op_t    push_op
);
  import pfe_pkg::*;

  logic            pend_v_r, pend_v_nxt;
  logic [CH_W-1:0] pend_c_r, pend_c_nxt;
  logic            prev_v_r, prev_v_nxt;
  logic [CH_W-1:0] prev_c_r, prev_c_nxt;
  logic            accept;
  logic            op_v;
  logic            pv, qv;
  logic [CH_W-1:0] c;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && op_v;

  always_comb begin
    op_v       = 1'b0;
    push_op    = '{kind: OP_KEY, a: in_chan.ch, b: CH_PAD,
                   first: in_chan.first, last: in_chan.last};
    pend_v_nxt = pend_v_r;
    pend_c_nxt = pend_c_r;
    prev_v_nxt = prev_v_r;
    prev_c_nxt = prev_c_r;
    pv         = pend_v_r && !in_chan.first;
    qv         = prev_v_r && !in_chan.first;
    c          = (qv && in_chan.ch == prev_c_r) ? CH_PAD : in_chan.ch;

    if (in_chan.cmd == CMD_KEY) begin
      op_v = 1'b1;
    end else begin
      pend_v_nxt = pv;
      prev_v_nxt = qv;
      if (in_chan.ch != CH_SPACE) begin
        prev_c_nxt = c;
        prev_v_nxt = 1'b1;
        if (pv) begin
          op_v       = 1'b1;
          push_op    = '{kind: OP_PAIR, a: pend_c_r, b: c, first: 1'b0,
                         last: in_chan.last};
          pend_v_nxt = 1'b0;
        end else begin
          pend_c_nxt = c;
          pend_v_nxt = 1'b1;
        end
      end
      if (in_chan.last) begin
        // odd tail gets padded
        if (pend_v_nxt) begin
          op_v    = 1'b1;
          push_op = '{kind: OP_PAIR, a: pend_c_nxt, b: CH_PAD, first: 1'b0,
                      last: 1'b1};
        end
        pend_v_nxt = 1'b0;
        prev_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      prev_v_r <= 1'b0;
    end else if (accept) begin
      pend_v_r <= pend_v_nxt;
      prev_v_r <= prev_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_c_r <= pend_c_nxt;
      prev_c_r <= prev_c_nxt;
    end
  end
endmodule

// File: src/pfe_queue.sv
// Small FIFO of operations between front end and back end.
module pfe_queue #(
  parameter int DEPTH = pfe_pkg::PFE_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pfe_pkg::pfe_op_t    push_op,
  input  logic                pop,
  output pfe_pkg::pfe_op_t    head_op,
  output pfe_pkg::pfe_qstat_t q_stat
);
  import pfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfe_op_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_op      = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end
endmodule

// File: src/pfe_back.sv
// Back end: builds the square, locates pairs, reads ciphertext from the square RAMs.
module pfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pfe_pkg::pfe_qstat_t q_stat,
  input  pfe_pkg::pfe_op_t    head_op,
  output logic                pop,
  pfe_out_if.source           out_chan,
  output pfe_pkg::pfe_bstat_t b_stat
);
  import pfe_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_KEY  = 6'b000010,
    ST_FILL = 6'b000100,
    ST_LOC  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_OUT  = 6'b100000
  } bk_state_t;

  bk_state_t        state_r, state_nxt;
  pfe_op_t          op_r;
  logic [CH_W-1:0]  cell_r [SQ_CELLS];
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] letter_r, letter_nxt;
  logic [CH_W-1:0]  letter;
  logic             add_en, dup, do_write;
  logic [CH_W-1:0]  add_ch;
  logic [IDX_W-1:0] add_base;

  logic [SQ_CELLS-1:0] m1, m2, s1, s2;
  logic [CH_W-1:0]     cval;
  logic [RC_W-1:0]     row1, col1, row2, col2;
  logic [IDX_W-1:0]    oidx1, oidx2;
  logic [IDX_W-1:0]    ridx1_r, ridx2_r;
  logic [CH_W-1:0]     q1, q2;

  logic            load;
  logic            out_v_r, out_v_nxt;
  logic [CH_W-1:0] out_c1_r, out_c2_r;
  logic            out_fin_r;

  assign letter = CH_LOW_A + CH_W'(letter_r);

  // Insert one character at the fill point unless already present.
  always_comb begin
    add_en   = 1'b0;
    add_ch   = op_r.a;
    add_base = fill_r;
    case (state_r)
      ST_KEY: begin
        add_en   = 1'b1;
        add_base = op_r.first ? '0 : fill_r;
      end
      ST_FILL: begin
        add_ch = letter;
        add_en = (letter_r < IDX_W'(ALPHA_LEN)) && (fill_r < IDX_W'(SQ_CELLS))
                 && (letter != CH_LOW_J);
      end
      default: ;
    endcase
    dup = 1'b0;
    for (int i = 0; i < SQ_CELLS; i++) begin
      dup = dup | ((IDX_W'(i) < add_base) && (cell_r[i] == add_ch));
    end
    do_write = add_en && (add_base < IDX_W'(SQ_CELLS)) && !dup;
    fill_nxt = fill_r;
    if (add_en) begin
      fill_nxt = do_write ? add_base + 1'b1 : add_base;
    end
  end

  // Locate both characters; the last matching cell wins, no match is cell 0.
  always_comb begin
    row1 = '0;
    col1 = '0;
    row2 = '0;
    col2 = '0;
    for (int i = 0; i < SQ_CELLS; i++) begin
      cval  = (IDX_W'(i) < fill_r) ? cell_r[i] : CH_SPACE;
      m1[i] = (cval == op_r.a);
      m2[i] = (cval == op_r.b);
    end
    for (int i = 0; i < SQ_CELLS; i++) begin
      s1[i] = m1[i] && !(|(m1 >> (i + 1)));
      s2[i] = m2[i] && !(|(m2 >> (i + 1)));
      row1  = row1 | (s1[i] ? CELL_ROW[i] : '0);
      col1  = col1 | (s1[i] ? CELL_COL[i] : '0);
      row2  = row2 | (s2[i] ? CELL_ROW[i] : '0);
      col2  = col2 | (s2[i] ? CELL_COL[i] : '0);
    end
    if (row1 == row2) begin
      oidx1 = cell_idx(row1, inc5(col1));
      oidx2 = cell_idx(row1, inc5(col2));
    end else if (col1 == col2) begin
      oidx1 = cell_idx(inc5(row1), col1);
      oidx2 = cell_idx(inc5(row2), col2);
    end else begin
      oidx1 = cell_idx(row1, col2);
      oidx2 = cell_idx(row2, col1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    load       = 1'b0;
    letter_nxt = letter_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = (head_op.kind == OP_KEY) ? ST_KEY : ST_LOC;
        end
      end
      ST_KEY: begin
        letter_nxt = '0;
        state_nxt  = op_r.last ? ST_FILL : ST_IDLE;
      end
      ST_FILL: begin
        if ((letter_r == IDX_W'(ALPHA_LEN)) || (fill_r == IDX_W'(SQ_CELLS))) begin
          state_nxt = ST_IDLE;
        end else begin
          letter_nxt = letter_r + 1'b1;
        end
      end
      ST_LOC: state_nxt = ST_RD;
      ST_RD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_v_r || out_chan.ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      letter_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      letter_r <= letter_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= head_op;
    end
    if (do_write) begin
      cell_r[add_base] <= add_ch;
    end
    if (state_r == ST_LOC) begin
      ridx1_r <= oidx1;
      ridx2_r <= oidx2;
    end
    if (load) begin
      out_c1_r  <= (ridx1_r < fill_r) ? q1 : CH_SPACE;
      out_c2_r  <= (ridx2_r < fill_r) ? q2 : CH_SPACE;
      out_fin_r <= op_r.last;
    end
  end

  // Two mirrored copies of the square, one per ciphertext character.
  pfe_ram #(.WIDTH(CH_W), .DEPTH(SQ_CELLS)) u_ram_a (
    .clk   (clk),
    .we    (do_write),
    .waddr (add_base),
    .wdata (add_ch),
    .raddr (ridx1_r),
    .rdata (q1)
  );

  pfe_ram #(.WIDTH(CH_W), .DEPTH(SQ_CELLS)) u_ram_b (
    .clk   (clk),
    .we    (do_write),
    .waddr (add_base),
    .wdata (add_ch),
    .raddr (ridx2_r),
    .rdata (q2)
  );

  assign out_chan.valid         = out_v_r;
  assign out_chan.cipher_first  = out_c1_r;
  assign out_chan.cipher_second = out_c2_r;
  assign out_chan.final_pair    = out_fin_r;
  assign b_stat.fill            = fill_r;
endmodule

// File: src/playfair_encrypt.sv
// Top level of the playfair encryptor.
//
// in_chan carries key characters (cmd 0) and message characters (cmd 1) with
// first/last framing; out_chan returns one ciphertext pair per plaintext pair,
// final_pair marking the last pair of a message. Both use valid/ready.
// A transfer on in_chan is taken whenever the op queue has room, so items are
// accepted one per cycle until the queue (QUEUE_DEPTH ops) fills.
// The back end runs one op at a time: a key character passes through the key
// state, a key character with last adds the alphabet fill (one letter per
// cycle), and a pair moves from queue head to the output register through the
// locate, square RAM read and output load states; the back end takes no new
// op from the queue until the current one is done.
// Spaces and the first half of a pair push no op, unless last pads an odd tail.
// Reset empties the queue, clears the square fill count (all cells read as
// space) and the message state; no clearing pass is needed.
// When out_chan stalls the finished pair waits in the output register, the
// back end holds its next pair and the queue then backs up into in_chan.ready.
`include "playfair_encrypt_defines.svh"

module playfair_encrypt #(
  parameter int QUEUE_DEPTH = pfe_pkg::PFE_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pfe_in_if.sink    in_chan,
  pfe_out_if.source out_chan
);
  import pfe_pkg::*;

  logic       push, pop;
  pfe_op_t    push_op, head_op;
  pfe_qstat_t q_stat;
  pfe_bstat_t b_stat;

  pfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  pfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  pfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_op  (head_op),
    .pop      (pop),
    .out_chan (out_chan),
    .b_stat   (b_stat)
  );

  `PFE_ASSERT_SAME(a_push_room, push, !q_stat.full)
  `PFE_ASSERT_SAME(a_pop_data, pop, !q_stat.empty)
  `PFE_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)
  `PFE_ASSERT_SAME(a_fill_range, 1'b1, b_stat.fill <= IDX_W'(SQ_CELLS))
endmodule
